[hw/rtl/adts_pkg.sv]
package adts_pkg;

	// Control modes, as reported in the result.
	localparam logic [1:0] MODE_LOCAL   = 2'd0;
	localparam logic [1:0] MODE_VISIBLE = 2'd1;
	localparam logic [1:0] MODE_REMOTE  = 2'd2;
	localparam logic [1:0] MODE_AUTO    = 2'd3;

	// Vehicle switch codes that force a mode.
	localparam logic [1:0] VCODE_LOCAL_MANUAL = 2'd0;
	localparam logic [1:0] VCODE_LOCAL_VISUAL = 2'd3;

	// Request kinds.
	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_BEACON = 1'b1;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INTERVAL      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_CEILING       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERSPEED_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERSPEED_THROTTLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_SPEED         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BEACON_TARGET      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_BEACON_TOLERANCE   = 3'd7;
	localparam int unsigned CFG_DATA_W = 19;

	// Configuration reset values.
	localparam logic [4:0]  RST_RAMP_INTERVAL      = 5'd20;
	localparam logic [6:0]  RST_RAMP_STEP          = 7'd10;
	localparam logic [6:0]  RST_RAMP_CEILING       = 7'd50;
	localparam logic [18:0] RST_OVERSPEED_LIMIT    = 19'd1390;
	localparam logic [6:0]  RST_OVERSPEED_THROTTLE = 7'd85;
	localparam logic [18:0] RST_STOP_SPEED         = 19'd40;
	localparam logic [15:0] RST_BEACON_TARGET      = 16'd275;
	localparam logic [15:0] RST_BEACON_TOLERANCE   = 16'd20;

	// Command limits and fixed gear codes.
	localparam logic [6:0] CMD_MAX           = 7'd127;
	localparam logic [3:0] GEAR_STOP_NEUTRAL = 4'd12;
	localparam logic [3:0] GEAR_FORWARD      = 4'd2;

	// floor(w*108/100) = floor(27w/25), done as (w * 27 * ceil(2^26/25)) >> 26.
	localparam logic [26:0] SPEED_MUL   = 27'd72477585;
	localparam int unsigned SPEED_SHIFT = 26;
	// floor(x*127/100), done as (x * 127 * ceil(2^21/100)) >> 21.
	localparam logic [21:0] SCALE_MUL   = 22'd2663444;
	localparam int unsigned SCALE_SHIFT = 21;

	typedef struct packed {
		logic        req_type;
		logic [15:0] beacon_length;
		logic [15:0] wheel_count;
		logic [1:0]  vehicle_mode_code;
		logic        operator_remote;
		logic        operator_visual;
		logic        operator_enable;
		logic [3:0]  operator_gear;
		logic [6:0]  operator_throttle;
		logic [6:0]  operator_brake;
	} in_item_t;

	typedef struct packed {
		logic [1:0] drive_mode;
		logic       frame_valid;
		logic [3:0] gear_bits;
		logic [6:0] throttle_cmd;
		logic [6:0] brake_cmd;
		logic       beacon_seen;
	} out_item_t;

	typedef struct packed {
		logic [4:0]  ramp_interval;
		logic [6:0]  ramp_step;
		logic [6:0]  ramp_ceiling;
		logic [18:0] overspeed_limit;
		logic [6:0]  overspeed_throttle;
		logic [18:0] stop_speed;
		logic [15:0] beacon_target;
		logic [15:0] beacon_tolerance;
	} cfg_t;

	// Request after the arithmetic that does not depend on state.
	typedef struct packed {
		logic        req_type;
		logic        beacon_match;
		logic [1:0]  vehicle_mode_code;
		logic        operator_remote;
		logic        operator_visual;
		logic        operator_enable;
		logic [3:0]  operator_gear;
		logic [18:0] speed;
		logic [6:0]  throttle_scaled;
		logic [6:0]  brake_scaled;
	} prep_t;

endpackage

[hw/rtl/adts_cfg.sv]
module adts_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [adts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [adts_pkg::CFG_DATA_W-1:0]     cfg_data,
	output adts_pkg::cfg_t                      cfg
);

	adts_pkg::cfg_t cfg_q;

	// Register file, written by index; the data is truncated to each register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ramp_interval      <= adts_pkg::RST_RAMP_INTERVAL;
			cfg_q.ramp_step          <= adts_pkg::RST_RAMP_STEP;
			cfg_q.ramp_ceiling       <= adts_pkg::RST_RAMP_CEILING;
			cfg_q.overspeed_limit    <= adts_pkg::RST_OVERSPEED_LIMIT;
			cfg_q.overspeed_throttle <= adts_pkg::RST_OVERSPEED_THROTTLE;
			cfg_q.stop_speed         <= adts_pkg::RST_STOP_SPEED;
			cfg_q.beacon_target      <= adts_pkg::RST_BEACON_TARGET;
			cfg_q.beacon_tolerance   <= adts_pkg::RST_BEACON_TOLERANCE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				adts_pkg::CFG_RAMP_INTERVAL:      cfg_q.ramp_interval      <= cfg_data[4:0];
				adts_pkg::CFG_RAMP_STEP:          cfg_q.ramp_step          <= cfg_data[6:0];
				adts_pkg::CFG_RAMP_CEILING:       cfg_q.ramp_ceiling       <= cfg_data[6:0];
				adts_pkg::CFG_OVERSPEED_LIMIT:    cfg_q.overspeed_limit    <= cfg_data[18:0];
				adts_pkg::CFG_OVERSPEED_THROTTLE: cfg_q.overspeed_throttle <= cfg_data[6:0];
				adts_pkg::CFG_STOP_SPEED:         cfg_q.stop_speed         <= cfg_data[18:0];
				adts_pkg::CFG_BEACON_TARGET:      cfg_q.beacon_target      <= cfg_data[15:0];
				adts_pkg::CFG_BEACON_TOLERANCE:   cfg_q.beacon_tolerance   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hw/rtl/adts_prep.sv]
module adts_prep (
	input  adts_pkg::in_item_t item,
	input  adts_pkg::cfg_t     cfg,
	output adts_pkg::prep_t    prep
);

	logic [42:0] speed_prod;
	logic [16:0] speed_base;
	logic [28:0] thr_prod;
	logic [28:0] brk_prod;
	logic [7:0]  thr_quot;
	logic [7:0]  brk_quot;
	logic [15:0] beacon_diff;

	// Speed is floor(wheel*1.08) times five, via a reciprocal multiply.
	assign speed_prod = 43'(item.wheel_count) * 43'(adts_pkg::SPEED_MUL);
	assign speed_base = speed_prod[adts_pkg::SPEED_SHIFT +: 17];

	// Percent to command byte scaling for remote mode.
	assign thr_prod = 29'(item.operator_throttle) * 29'(adts_pkg::SCALE_MUL);
	assign brk_prod = 29'(item.operator_brake) * 29'(adts_pkg::SCALE_MUL);
	assign thr_quot = thr_prod[adts_pkg::SCALE_SHIFT +: 8];
	assign brk_quot = brk_prod[adts_pkg::SCALE_SHIFT +: 8];

	// Absolute distance of the measured beacon length from the target.
	assign beacon_diff = (item.beacon_length > cfg.beacon_target) ?
		(item.beacon_length - cfg.beacon_target) : (cfg.beacon_target - item.beacon_length);

	always_comb begin
		prep.req_type          = item.req_type;
		prep.beacon_match      = beacon_diff < cfg.beacon_tolerance;
		prep.vehicle_mode_code = item.vehicle_mode_code;
		prep.operator_remote   = item.operator_remote;
		prep.operator_visual   = item.operator_visual;
		prep.operator_enable   = item.operator_enable;
		prep.operator_gear     = item.operator_gear;
		prep.speed             = (19'(speed_base) << 2) + 19'(speed_base);
		prep.throttle_scaled   = thr_quot[7] ? adts_pkg::CMD_MAX : thr_quot[6:0];
		prep.brake_scaled      = brk_quot[7] ? adts_pkg::CMD_MAX : brk_quot[6:0];
	end

endmodule

[hw/rtl/adts_ctrl.sv]
module adts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  adts_pkg::prep_t     req,
	input  adts_pkg::cfg_t      cfg,
	output adts_pkg::out_item_t result
);

	logic [1:0] mode_q;
	logic [4:0] div_q;
	logic [6:0] thr_q;
	logic [6:0] brk_q;
	logic [3:0] gear_q;
	logic       latch_q;

	logic [1:0] mode_n;
	logic [4:0] div_n;
	logic [6:0] thr_n;
	logic [6:0] brk_n;
	logic [3:0] gear_n;
	logic       fire;
	logic       go;
	logic [7:0] thr_sum;

	// Mode decision: forced codes first, then the console, else hold.
	always_comb begin
		mode_n = mode_q;
		if (req.vehicle_mode_code == adts_pkg::VCODE_LOCAL_MANUAL) begin
			mode_n = adts_pkg::MODE_LOCAL;
		end else if (req.vehicle_mode_code == adts_pkg::VCODE_LOCAL_VISUAL) begin
			mode_n = adts_pkg::MODE_VISIBLE;
		end else if (req.operator_remote) begin
			mode_n = req.operator_visual ? adts_pkg::MODE_AUTO : adts_pkg::MODE_REMOTE;
		end
	end

	// Tick divider and the ramp trigger.
	assign div_n   = (div_q < cfg.ramp_interval) ? (div_q + 5'd1) : 5'd0;
	assign fire    = div_n == cfg.ramp_interval;
	assign go      = req.operator_enable && !latch_q;
	assign thr_sum = {1'b0, thr_q} + {1'b0, cfg.ramp_step};

	// Throttle ramp, brake and gear update.
	always_comb begin
		thr_n  = thr_q;
		brk_n  = brk_q;
		gear_n = gear_q;
		if (fire) begin
			if (go) begin
				if (req.speed > cfg.overspeed_limit) begin
					thr_n = cfg.overspeed_throttle;
				end else if (thr_q < cfg.ramp_ceiling) begin
					thr_n = thr_sum[7] ? adts_pkg::CMD_MAX : thr_sum[6:0];
				end
				if (thr_n != 7'd0) begin
					brk_n  = 7'd0;
					gear_n = req.operator_gear;
				end
			end else begin
				if (thr_q >= cfg.ramp_step) begin
					thr_n = thr_q - cfg.ramp_step;
				end
				if (thr_n == 7'd0) begin
					brk_n = adts_pkg::CMD_MAX;
					if (req.speed < cfg.stop_speed) begin
						gear_n = adts_pkg::GEAR_STOP_NEUTRAL;
					end
				end
			end
		end
	end

	// State update when a request leaves this stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= adts_pkg::MODE_LOCAL;
			div_q   <= 5'd0;
			thr_q   <= 7'd0;
			brk_q   <= 7'd0;
			gear_q  <= adts_pkg::GEAR_FORWARD;
			latch_q <= 1'b0;
		end else if (en) begin
			if (req.req_type == adts_pkg::REQ_BEACON) begin
				if (req.beacon_match) begin
					latch_q <= 1'b1;
				end
			end else begin
				mode_q <= mode_n;
				if (mode_n == adts_pkg::MODE_AUTO) begin
					div_q  <= div_n;
					thr_q  <= thr_n;
					brk_q  <= brk_n;
					gear_q <= gear_n;
				end
			end
		end
	end

	// Result of a tick request, built from the updated state.
	always_comb begin
		result.drive_mode   = mode_n;
		result.beacon_seen  = latch_q;
		result.frame_valid  = 1'b0;
		result.gear_bits    = 4'd0;
		result.throttle_cmd = 7'd0;
		result.brake_cmd    = 7'd0;
		case (mode_n)
			adts_pkg::MODE_AUTO: begin
				result.frame_valid  = 1'b1;
				result.gear_bits    = gear_n;
				result.throttle_cmd = thr_n;
				result.brake_cmd    = brk_n;
			end
			adts_pkg::MODE_REMOTE: begin
				result.frame_valid  = 1'b1;
				result.gear_bits    = req.operator_gear;
				result.throttle_cmd = req.throttle_scaled;
				result.brake_cmd    = req.brake_scaled;
			end
			default: ;
		endcase
	end

endmodule

[hw/rtl/auto_drive_throttle_supervisor.sv]
// Drive supervisor for a vehicle. Requests arrive on the item channel
// (item_valid/item_ready, payload item). A tick request yields exactly one
// result on the result channel (result_valid/result_ready, payload result);
// a beacon request only updates the stop latch and yields nothing.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// take effect at the next clock edge; write them only while the block is idle.
// A request is accepted into the input register, moves on to the arithmetic
// register and then into the result register, where the result of a tick
// request is presented. Throughput is one request per cycle while the receiver
// does not stall; the control stage holds the mode, divider, throttle, brake,
// gear and latch, and updates that state whenever a request leaves it.
// When the receiver stalls, the result register holds its value and the
// pipeline behind it fills; item_ready drops once all three stages are
// occupied, and beacon requests still drain since they need no result slot.
// Reset clears all pipeline valids, puts the block in local mode with zero
// throttle and brake, forward gear, a clear latch and the default
// configuration values.
module auto_drive_throttle_supervisor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  adts_pkg::in_item_t              item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output adts_pkg::out_item_t             result,
	input  logic                            cfg_we,
	input  logic [adts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [adts_pkg::CFG_DATA_W-1:0] cfg_data
);

	adts_pkg::cfg_t      cfg;
	adts_pkg::in_item_t  item_s1;
	logic                valid_s1;
	adts_pkg::prep_t     prep_comb;
	adts_pkg::prep_t     prep_s2;
	logic                valid_s2;
	adts_pkg::out_item_t res_comb;
	adts_pkg::out_item_t result_q;
	logic                result_valid_q;

	logic go_s2;
	logic free_s2;
	logic go_s1;

	adts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	adts_prep u_prep (
		.item (item_s1),
		.cfg  (cfg),
		.prep (prep_comb)
	);

	adts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (go_s2),
		.req    (prep_s2),
		.cfg    (cfg),
		.result (res_comb)
	);

	// Stage flow: a beacon request leaves the control stage without a result slot.
	assign go_s2      = valid_s2 && ((prep_s2.req_type == adts_pkg::REQ_BEACON) ||
		!result_valid_q || result_ready);
	assign free_s2    = !valid_s2 || go_s2;
	assign go_s1      = valid_s1 && free_s2;
	assign item_ready = !valid_s1 || go_s1;

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (free_s2) begin
				valid_s2 <= go_s1;
			end
		end
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (go_s1) begin
			prep_s2 <= prep_comb;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (go_s2 && (prep_s2.req_type == adts_pkg::REQ_TICK)) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2 && (prep_s2.req_type == adts_pkg::REQ_TICK)) begin
			result_q <= res_comb;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
